// ===== rtl/esr_pkg.sv =====
`default_nettype none
package esr_pkg;

  localparam int SUBSCRIBERS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int EV_W   = 16;
  localparam int HD_W   = 8;
  localparam int TAG_W  = 32;
  localparam int ARG_W  = 32;
  localparam int SLOT_W = 8;
  localparam int REM_W  = 4;
  localparam int ST_W   = 3;
  localparam int CMD_W  = 3;
  localparam int ENT_W  = EV_W + HD_W + TAG_W;
  localparam int QENT_W = EV_W + ARG_W;

  localparam logic [CMD_W-1:0] CMD_SUB      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UNSUB    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNSLOT   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PUB      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PUBSYNC  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd5;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_NOSUB   = 3'd1;
  localparam logic [ST_W-1:0] ST_INVALID = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFND  = 3'd3;
  localparam logic [ST_W-1:0] ST_NOROOM  = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_QREAD,
    S_QWAIT,
    S_SCAN,
    S_SCANW,
    S_NOTE,
    S_PUSH,
    S_STATUS,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/esr_ram.sv =====
`default_nettype none
module esr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/event_subscriber_router_core.sv =====
`default_nettype none
// Channel   Direction  Contents
// in_       slave      command transaction
// out_      master     notification and status transactions
//
// Each walking command reads the subscriber table one slot at a time through a
// registered-read RAM; unsubscribe by slot clears its entry straight from idle. Publish
// sync with a subscriber walks the table twice and sends one notification per match in
// the second walk; dispatch does the same for each queued event. After reset a clearing
// pass writes every table slot before a command is taken. A result waits in the output
// register while out_tready is low; the walk stalls.
module event_subscriber_router_core #(
  parameter int SUBSCRIBERS = esr_pkg::SUBSCRIBERS_DEF,
  parameter int QUEUE_DEPTH = esr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // command[2:0], event_code[18:3], handler[26:19], user_tag[58:27], tag_given[59],
  // slot[67:60], arg[99:68], zero[103:100]
  input  wire logic [103:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // kind[0], status[3:1], slot_out[11:4], handler_out[19:12], tag_out[51:20],
  // event_out[67:52], remaining[71:68], arg_out[103:72]
  output logic [103:0]      out_tdata,
  output logic              out_tlast
);
  localparam int SA_W = (SUBSCRIBERS > 1) ? $clog2(SUBSCRIBERS) : 1;
  localparam int SD   = (SUBSCRIBERS > 1) ? SUBSCRIBERS : 2;
  localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QD   = (QUEUE_DEPTH > 1) ? QUEUE_DEPTH : 2;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SC_W = $clog2(SUBSCRIBERS + 1);
  localparam int EV_W = esr_pkg::EV_W;
  localparam int HD_W = esr_pkg::HD_W;
  localparam int TAG_W = esr_pkg::TAG_W;
  localparam int ARG_W = esr_pkg::ARG_W;

  esr_pkg::state_t state_r, state_nxt;

  logic [esr_pkg::CMD_W-1:0] cmd_r;
  logic [EV_W-1:0]  ev_r;
  logic [HD_W-1:0]  hd_r;
  logic [TAG_W-1:0] tag_r;
  logic             tg_r;
  logic [7:0]       slot_r;
  logic [ARG_W-1:0] arg_r;

  logic [SA_W:0]    idx_r;
  logic             pass_r;
  logic [SC_W-1:0]  cnt_r;
  logic             found_r, done_r;
  logic [esr_pkg::ST_W-1:0] st_r;
  logic [7:0]       stslot_r;
  logic [QA_W-1:0]  head_r;
  logic [QC_W-1:0]  qcnt_r;
  logic             disp_r;

  logic [103:0]     odata_r;
  logic             ovalid_r, olast_r;

  logic             s_we;
  logic [SA_W-1:0]  s_waddr, s_raddr;
  logic [esr_pkg::ENT_W-1:0] s_wdata, s_rdata;
  logic             q_we;
  logic [QA_W-1:0]  q_waddr, q_raddr;
  logic [esr_pkg::QENT_W-1:0] q_rdata;

  esr_ram #(.WIDTH(esr_pkg::ENT_W), .DEPTH(SD)) u_sub (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );
  esr_ram #(.WIDTH(esr_pkg::QENT_W), .DEPTH(QD)) u_q (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata({arg_r, ev_r}),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  logic [EV_W-1:0]  e_ev;
  logic [HD_W-1:0]  e_hd;
  logic [TAG_W-1:0] e_tag;
  assign e_ev  = s_rdata[EV_W-1:0];
  assign e_hd  = s_rdata[EV_W+HD_W-1:EV_W];
  assign e_tag = s_rdata[esr_pkg::ENT_W-1:EV_W+HD_W];

  logic [SA_W-1:0] cur;
  logic            last_idx;
  logic            sub_match, uns_match;
  assign cur = idx_r[SA_W-1:0];
  assign last_idx = (idx_r == (SA_W+1)'(SUBSCRIBERS - 1));
  assign sub_match = (e_hd != '0) && (e_ev == ev_r) && (ev_r != '0);
  assign uns_match = ((ev_r == '0) || (e_ev == ev_r)) &&
                     ((hd_r == '0) || ((e_hd == hd_r) && (!tg_r || e_tag == tag_r)));

  logic [7:0]                rem_full;
  logic [esr_pkg::REM_W-1:0] rem_sat;
  assign rem_full = 8'(cnt_r) - 8'd1;
  assign rem_sat  = (rem_full > 8'd15) ? 4'd15 : rem_full[3:0];

  logic [QA_W-1:0] wptr;
  always_comb begin
    logic [QA_W:0] s;
    s = {1'b0, head_r} + (QA_W+1)'(qcnt_r);
    if (s >= (QA_W+1)'(QUEUE_DEPTH)) begin
      s = s - (QA_W+1)'(QUEUE_DEPTH);
    end
    wptr = s[QA_W-1:0];
  end

  logic [QA_W-1:0] head_inc;
  assign head_inc = (head_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;

  logic out_free;
  assign out_free = !ovalid_r || out_tready;

  logic oload;
  assign oload = out_free &&
                 ((state_r == esr_pkg::S_NOTE) || (state_r == esr_pkg::S_STATUS));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      esr_pkg::S_CLEAR:  if (last_idx) state_nxt = esr_pkg::S_IDLE;
      esr_pkg::S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_tdata[2:0])
            esr_pkg::CMD_SUB: state_nxt = (in_tdata[26:19] == '0) ?
                                          esr_pkg::S_STATUS : esr_pkg::S_SCAN;
            esr_pkg::CMD_UNSUB: state_nxt = (in_tdata[18:3] == '0 && in_tdata[26:19] == '0) ?
                                            esr_pkg::S_STATUS : esr_pkg::S_SCAN;
            esr_pkg::CMD_UNSLOT, esr_pkg::CMD_DISPATCH: state_nxt = esr_pkg::S_STATUS;
            esr_pkg::CMD_PUB, esr_pkg::CMD_PUBSYNC: state_nxt = (in_tdata[18:3] == '0) ?
                                                    esr_pkg::S_STATUS : esr_pkg::S_SCAN;
            default: state_nxt = esr_pkg::S_STATUS;
          endcase
          if (in_tdata[2:0] == esr_pkg::CMD_DISPATCH) state_nxt = esr_pkg::S_QREAD;
        end
      end
      esr_pkg::S_QREAD:  state_nxt = (qcnt_r == '0) ? esr_pkg::S_STATUS : esr_pkg::S_QWAIT;
      esr_pkg::S_QWAIT:  state_nxt = esr_pkg::S_SCAN;
      esr_pkg::S_SCAN:   state_nxt = esr_pkg::S_SCANW;
      esr_pkg::S_SCANW: begin
        state_nxt = esr_pkg::S_SCAN;
        if (pass_r && sub_match) state_nxt = esr_pkg::S_NOTE;
        else if (last_idx || done_r) begin
          if (cmd_r == esr_pkg::CMD_PUB) state_nxt = esr_pkg::S_PUSH;
          else if (cmd_r == esr_pkg::CMD_PUBSYNC || cmd_r == esr_pkg::CMD_DISPATCH) begin
            if (!pass_r && (cnt_r != '0 || sub_match)) state_nxt = esr_pkg::S_SCAN;
            else if (cmd_r == esr_pkg::CMD_DISPATCH) state_nxt = esr_pkg::S_QREAD;
            else state_nxt = esr_pkg::S_STATUS;
          end else state_nxt = esr_pkg::S_STATUS;
        end
        if (cmd_r == esr_pkg::CMD_SUB && e_hd == '0) state_nxt = esr_pkg::S_STATUS;
        if (cmd_r == esr_pkg::CMD_UNSUB && uns_match && ev_r != '0 && hd_r != '0 && tg_r)
          state_nxt = esr_pkg::S_STATUS;
      end
      esr_pkg::S_NOTE: begin
        if (out_free) begin
          if (!last_idx) state_nxt = esr_pkg::S_SCAN;
          else if (cmd_r == esr_pkg::CMD_DISPATCH) state_nxt = esr_pkg::S_QREAD;
          else state_nxt = esr_pkg::S_STATUS;
        end
      end
      esr_pkg::S_PUSH:   state_nxt = esr_pkg::S_STATUS;
      esr_pkg::S_STATUS: if (out_free) state_nxt = esr_pkg::S_OUT;
      esr_pkg::S_OUT:    state_nxt = esr_pkg::S_IDLE;
      default:           state_nxt = esr_pkg::S_IDLE;
    endcase
  end

  assign in_tready = (state_r == esr_pkg::S_IDLE);

  always_comb begin
    s_we = 1'b0;
    s_waddr = cur;
    s_wdata = '0;
    s_raddr = cur;
    q_we = (state_r == esr_pkg::S_PUSH) && (st_r == esr_pkg::ST_OK);
    q_waddr = wptr;
    q_raddr = head_r;
    unique case (state_r)
      esr_pkg::S_CLEAR: s_we = 1'b1;
      esr_pkg::S_IDLE: begin
        s_waddr = in_tdata[60 +: SA_W];
        s_we = in_tvalid && (in_tdata[2:0] == esr_pkg::CMD_UNSLOT) &&
               (in_tdata[67:60] < 8'(SUBSCRIBERS));
      end
      esr_pkg::S_SCANW: begin
        if (cmd_r == esr_pkg::CMD_SUB && e_hd == '0) begin
          s_we = 1'b1;
          s_wdata = {tag_r, hd_r, ev_r};
        end
        if (cmd_r == esr_pkg::CMD_UNSUB && uns_match) s_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= esr_pkg::S_CLEAR;
      idx_r <= '0;
      head_r <= '0;
      qcnt_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (oload) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        esr_pkg::S_CLEAR: idx_r <= idx_r + 1'b1;
        esr_pkg::S_IDLE: begin
          idx_r <= '0;
          pass_r <= 1'b0;
          cnt_r <= '0;
          found_r <= 1'b0;
          done_r <= 1'b0;
          stslot_r <= '0;
          if (in_tvalid) begin
            cmd_r <= in_tdata[2:0];
            ev_r <= in_tdata[18:3];
            hd_r <= in_tdata[26:19];
            tag_r <= in_tdata[58:27];
            tg_r <= in_tdata[59];
            slot_r <= in_tdata[67:60];
            arg_r <= in_tdata[99:68];
            st_r <= esr_pkg::ST_INVALID;
            unique case (in_tdata[2:0])
              esr_pkg::CMD_SUB: st_r <= (in_tdata[26:19] == '0) ?
                                        esr_pkg::ST_INVALID : esr_pkg::ST_NOROOM;
              esr_pkg::CMD_UNSLOT: st_r <= (in_tdata[67:60] < 8'(SUBSCRIBERS)) ?
                                           esr_pkg::ST_OK : esr_pkg::ST_INVALID;
              esr_pkg::CMD_DISPATCH: st_r <= esr_pkg::ST_OK;
              default: ;
            endcase
          end
        end
        esr_pkg::S_QREAD: begin
          if (qcnt_r != '0) begin
            head_r <= head_inc;
            qcnt_r <= qcnt_r - 1'b1;
          end
          idx_r <= '0;
          pass_r <= 1'b0;
          cnt_r <= '0;
        end
        esr_pkg::S_QWAIT: begin
          ev_r <= q_rdata[EV_W-1:0];
          arg_r <= q_rdata[esr_pkg::QENT_W-1:EV_W];
        end
        esr_pkg::S_SCANW: begin
          if (!pass_r && sub_match) cnt_r <= cnt_r + 1'b1;
          if (cmd_r == esr_pkg::CMD_UNSUB && uns_match) found_r <= 1'b1;
          if (cmd_r == esr_pkg::CMD_SUB && e_hd == '0) begin
            st_r <= esr_pkg::ST_OK;
            stslot_r <= 8'(cur);
          end
          if (!(pass_r && sub_match)) begin
            if (last_idx) begin
              idx_r <= '0;
              if (!pass_r && (cnt_r != '0 || sub_match) && cmd_r != esr_pkg::CMD_PUB)
                pass_r <= 1'b1;
            end else idx_r <= idx_r + 1'b1;
            if (last_idx) begin
              unique case (cmd_r)
                esr_pkg::CMD_UNSUB: st_r <= (found_r || uns_match) ?
                                           esr_pkg::ST_OK : esr_pkg::ST_NOTFND;
                esr_pkg::CMD_PUB:
                  st_r <= ((cnt_r == '0) && !sub_match) ? esr_pkg::ST_NOSUB :
                          (qcnt_r >= QC_W'(QUEUE_DEPTH)) ? esr_pkg::ST_NOROOM : esr_pkg::ST_OK;
                esr_pkg::CMD_PUBSYNC, esr_pkg::CMD_DISPATCH:
                  st_r <= (!pass_r && cnt_r == '0 && !sub_match) ?
                          esr_pkg::ST_NOSUB : esr_pkg::ST_OK;
                default: ;
              endcase
            end
          end
          if (cmd_r == esr_pkg::CMD_UNSUB && uns_match && ev_r != '0 && hd_r != '0 && tg_r)
            st_r <= esr_pkg::ST_OK;
        end
        esr_pkg::S_NOTE: begin
          if (out_free) begin
            olast_r <= 1'b0;
            odata_r <= {arg_r, rem_sat, ev_r, e_tag, e_hd, 8'(cur),
                        esr_pkg::ST_OK, 1'b1};
            cnt_r <= cnt_r - 1'b1;
            if (last_idx) idx_r <= '0;
            else idx_r <= idx_r + 1'b1;
            if (last_idx) st_r <= esr_pkg::ST_OK;
          end
        end
        esr_pkg::S_PUSH: if (st_r == esr_pkg::ST_OK) qcnt_r <= qcnt_r + 1'b1;
        esr_pkg::S_STATUS: begin
          if (out_free) begin
            olast_r <= 1'b1;
            odata_r <= {32'd0, 4'd0, 16'd0, 32'd0, 8'd0, stslot_r, st_r, 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  logic unused;
  assign unused = ^{slot_r, in_tdata[103:100]};
endmodule
`default_nettype wire
